[rtl/core/bms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_pkg
// shared constants and types for the batch median sorter
// ----------------------------------------------------------------------------
package bms_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int SAMPLE_W    = 32;
    localparam int USED_W      = 7;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W       = $clog2(MAX_SAMPLES);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic        [CNT_W-1:0]    t_count;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

endpackage

[rtl/core/bms_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_cell
// one compare-and-shift storage cell of the sorting chain
// ----------------------------------------------------------------------------
module bms_cell (
    input  logic               i_clk,
    input  bms_pkg::t_cell_ctl i_ctl,
    input  bms_pkg::t_sample   i_x,
    input  logic               i_occ,
    input  logic               i_at_end,
    input  logic               i_prev_gt,
    input  bms_pkg::t_sample   i_prev_val,
    input  bms_pkg::t_sample   i_next_val,
    output logic               o_gt,
    output bms_pkg::t_sample   o_val
);
    import bms_pkg::*;

    t_sample r_val;
    t_sample n_val;

    // cell is occupied and its held value is larger than the incoming sample
    assign o_gt  = i_occ && (r_val > i_x);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.shift) begin
            n_val = i_next_val;
        end else if (i_ctl.insert) begin
            if (i_prev_gt) begin
                n_val = i_prev_val;
            end else if (o_gt || i_at_end) begin
                n_val = i_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

[rtl/core/bms_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bms_chain
// row of sorting cells, ascending from cell 0
// ----------------------------------------------------------------------------
module bms_chain (
    input  logic               i_clk,
    input  bms_pkg::t_cell_ctl i_ctl,
    input  bms_pkg::t_sample   i_x,
    input  bms_pkg::t_count    i_count,
    output bms_pkg::t_sample   o_head0,
    output bms_pkg::t_sample   o_head1
);
    import bms_pkg::*;

    logic    gt  [MAX_SAMPLES];
    t_sample val [MAX_SAMPLES];

    for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
        logic    occ;
        logic    at_end;
        logic    prev_gt;
        t_sample prev_val;
        t_sample next_val;

        assign occ    = (CNT_W'(g) < i_count);
        assign at_end = (CNT_W'(g) == i_count);

        if (g == 0) begin : g_first
            assign prev_gt  = 1'b0;
            assign prev_val = '0;
        end else begin : g_mid
            assign prev_gt  = gt[g-1];
            assign prev_val = val[g-1];
        end

        if (g == MAX_SAMPLES - 1) begin : g_last
            assign next_val = '0;
        end else begin : g_inner
            assign next_val = val[g+1];
        end

        bms_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_x        (i_x),
            .i_occ      (occ),
            .i_at_end   (at_end),
            .i_prev_gt  (prev_gt),
            .i_prev_val (prev_val),
            .i_next_val (next_val),
            .o_gt       (gt[g]),
            .o_val      (val[g])
        );
    end

    assign o_head0 = val[0];
    assign o_head1 = val[1];

endmodule

[rtl/core/batch_median_sorter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batch_median_sorter
// streaming median of a batch of signed Q16.16 samples via an insertion chain
// ----------------------------------------------------------------------------
// throughput: one sample per cycle while a batch is filling
// after last: following the transaction carrying last, the chain shifts
//   toward cell 0 by floor((n-1)/2) places in the seek state; the fsm then
//   moves to the load state, which loads the result register once no stalled
//   earlier result still holds it; input is stalled for that span
// reset: synchronous active low, clears fill count, overflow flag, fsm and
//   output valid; cell contents are not reset
// ----------------------------------------------------------------------------
module batch_median_sorter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [bms_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_last,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [bms_pkg::SAMPLE_W-1:0] o_median_value,
    output logic        [bms_pkg::USED_W-1:0]   o_samples_used,
    output logic                          o_overflowed
);
    import bms_pkg::*;

    // one-hot control states
    typedef enum logic [2:0] {
        S_FILL = 3'b001,
        S_SEEK = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state           r_state,  n_state;
    t_count           r_count,  n_count;
    logic             r_ovf,    n_ovf;
    logic [IDX_W-1:0] r_seek,   n_seek;
    logic             r_odd,    n_odd;
    t_count           r_used,   n_used;
    logic             r_out_valid, n_out_valid;
    t_sample          r_med,    n_med;
    logic [USED_W-1:0] r_oused, n_oused;
    logic             r_oovf,   n_oovf;

    t_cell_ctl        ctl;
    t_sample          head0;
    t_sample          head1;
    logic             accept;
    logic             full;
    t_count           n_total;
    logic             out_free;
    logic [SAMPLE_W:0] pair_sum;
    logic [CNT_W+USED_W-1:0] used_ext;

    assign o_in_stall = (r_state != S_FILL);
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CNT_W'(MAX_SAMPLES));
    // batch size including the sample just accepted, if it fit
    assign n_total    = full ? r_count : (r_count + CNT_W'(1));
    assign out_free   = !r_out_valid || !i_out_stall;

    // two middle elements summed in 33 bits, arithmetic shift by one
    assign pair_sum   = {head0[SAMPLE_W-1], head0} + {head1[SAMPLE_W-1], head1};
    // samples_used is the count wrapped to its field width
    assign used_ext   = {{USED_W{1'b0}}, r_used};

    always_comb begin
        ctl.insert = accept && !full;
        ctl.shift  = (r_state == S_SEEK) && (r_seek != '0);
    end

    bms_chain u_chain (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_x     (i_sample),
        .i_count (r_count),
        .o_head0 (head0),
        .o_head1 (head1)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_seek      = r_seek;
        n_odd       = r_odd;
        n_used      = r_used;
        n_out_valid = r_out_valid && i_out_stall;
        n_med       = r_med;
        n_oused     = r_oused;
        n_oovf      = r_oovf;

        unique case (r_state)
            S_FILL: begin
                if (accept) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_last) begin
                        // shifts needed to bring the lower middle to cell 0
                        n_used = n_total;
                        n_odd  = n_total[0];
                        n_seek = n_total[0] ? IDX_W'(n_total >> 1)
                                            : IDX_W'((n_total >> 1) - CNT_W'(1));
                        n_state = S_SEEK;
                    end
                end
            end
            S_SEEK: begin
                if (r_seek != '0) begin
                    n_seek = r_seek - IDX_W'(1);
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // wait here until the result register is free
                if (out_free) begin
                    n_med       = r_odd ? head0 : t_sample'(pair_sum[SAMPLE_W:1]);
                    n_oused     = used_ext[USED_W-1:0];
                    n_oovf      = r_ovf;
                    n_out_valid = 1'b1;
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_state     = S_FILL;
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_seek  <= n_seek;
        r_odd   <= n_odd;
        r_used  <= n_used;
        r_med   <= n_med;
        r_oused <= n_oused;
        r_oovf  <= n_oovf;
    end

    assign o_out_valid    = r_out_valid;
    assign o_median_value = r_med;
    assign o_samples_used = r_oused;
    assign o_overflowed   = r_oovf;

    // fill count never exceeds the chain length
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("fill count beyond capacity");

    // a closing transaction always starts the median search
    a_last_seek: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> (r_state == S_SEEK))
        else $error("last transaction did not start seek");

    // a new result only comes from the load state
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_out_valid && !(r_out_valid && i_out_stall)) |-> (r_state == S_LOAD))
        else $error("result loaded outside load state");

    // the chain never shifts and inserts in the same cycle
    a_ctl_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctl.insert && ctl.shift))
        else $error("insert and shift together");

endmodule

[bench/tb_batch_median_sorter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_batch_median_sorter
// self-checking bench for the streaming batch median sorter
// ----------------------------------------------------------------------------
// drives batches of signed q16.16 samples through the valid/stall input
// channel, keeps its own sorted copy of each batch to predict the median,
// sample count and overflow flag, and checks every result transaction in
// order. starts with hand-picked edge batches, then random batches of mixed
// sizes and value spreads, some of them longer than the store. both channels
// idle and stall at random except during one quiet stretch.
// ----------------------------------------------------------------------------
module tb_batch_median_sorter;

    import bms_pkg::*;

    localparam int ITEM_TARGET  = 1200;
    localparam int QUIET_LIMIT  = 4000;
    localparam int IDLE_PERCENT = 7;
    localparam int SETTLE_CYCLES = MAX_SAMPLES / 2 + 8;

    // value spreads used by the random batches
    typedef enum int {
        MIX_FULL,
        MIX_NARROW,
        MIX_EXTREME,
        MIX_EDGE
    } sample_mix_e;

    // one predicted result transaction
    typedef struct {
        t_sample           median;
        logic [USED_W-1:0] used;
        logic              ovf;
    } median_exp_t;

    // ------------------------------------------------------------------------
    // median tracker: sorted copy of the open batch plus queue of medians
    // ------------------------------------------------------------------------
    class median_tracker;
        t_sample     batch_sorted [MAX_SAMPLES];
        int          fill;
        bit          dropped;
        median_exp_t pending_medians [$];
        int          mismatches;
        int          results_seen;

        function new();
            fill         = 0;
            dropped      = 0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // insertion after any equal entries, then median when the batch closes
        function void take_sample(t_sample s, logic last);
            int                 pos;
            logic signed [32:0] pair_sum;
            median_exp_t        e;
            if (fill < MAX_SAMPLES) begin
                pos = fill;
                while (pos > 0 && batch_sorted[pos-1] > s) begin
                    batch_sorted[pos] = batch_sorted[pos-1];
                    pos--;
                end
                batch_sorted[pos] = s;
                fill++;
            end else begin
                dropped = 1'b1;
            end
            if (last) begin
                if (fill % 2 == 0) begin
                    // 33-bit sum, arithmetic shift right by one (floor)
                    pair_sum = {batch_sorted[fill/2-1][SAMPLE_W-1], batch_sorted[fill/2-1]}
                             + {batch_sorted[fill/2][SAMPLE_W-1], batch_sorted[fill/2]};
                    e.median = pair_sum[SAMPLE_W:1];
                end else begin
                    e.median = batch_sorted[fill/2];
                end
                e.used  = fill[USED_W-1:0];
                e.ovf   = dropped;
                pending_medians.push_back(e);
                fill    = 0;
                dropped = 1'b0;
            end
        endfunction

        function void check_median(t_sample m, logic [USED_W-1:0] u, logic o);
            median_exp_t e;
            results_seen++;
            if (pending_medians.size() == 0) begin
                $error("unexpected result: median_value %0d samples_used %0d overflowed %0b",
                       m, u, o);
                mismatches++;
                return;
            end
            e = pending_medians.pop_front();
            if (m !== e.median) begin
                $error("median_value expected %0d actual %0d", e.median, m);
                mismatches++;
            end
            if (u !== e.used) begin
                $error("samples_used expected %0d actual %0d", e.used, u);
                mismatches++;
            end
            if (o !== e.ovf) begin
                $error("overflowed expected %0b actual %0b", e.ovf, o);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // dut signals, every input known from time zero
    // ------------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_sample           i_sample    = '0;
    logic              i_last      = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_sample           o_median_value;
    logic [USED_W-1:0] o_samples_used;
    logic              o_overflowed;

    median_tracker tracker = new();

    bit no_idle          = 1'b0;  // quiet stretch: neither side idles
    int items_sent       = 0;
    int batches_sent     = 0;
    int overflow_batches = 0;
    int quiet_cycles     = 0;

    batch_median_sorter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_median_value (o_median_value),
        .o_samples_used (o_samples_used),
        .o_overflowed   (o_overflowed)
    );

    // 12 ns period
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // result side: check accepted transactions, stall at random
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_median(o_median_value, o_samples_used, o_overflowed);
        end
        i_out_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
    end

    // ------------------------------------------------------------------------
    // watchdog: too many cycles in a row without any transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // one sample transaction, with optional idle cycles in front of it
    task automatic send_sample(t_sample s, logic last);
        while (!no_idle && ($urandom_range(99) < IDLE_PERCENT)) begin
            i_in_valid <= 1'b0;
            i_sample   <= $urandom;     // junk payload while idle
            i_last     <= $urandom_range(1);
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        i_last     <= last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        // accepted at this edge
        tracker.take_sample(s, last);
        items_sent++;
        if (last) begin
            batches_sent++;
        end
    endtask

    // hold until every predicted median has come back; watchdog guards it
    task automatic wait_for_drain();
        while (tracker.pending_medians.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_sample pick_sample(sample_mix_e mix);
        t_sample v;
        case (mix)
            MIX_FULL: begin
                v = $urandom;
            end
            MIX_NARROW: begin
                // lots of duplicates around zero
                v = int'($urandom_range(16)) - 8;
            end
            MIX_EXTREME: begin
                case ($urandom_range(5))
                    0:       v = 32'sh7FFFFFFF;
                    1:       v = 32'sh80000000;
                    2:       v = 32'sh00000000;
                    3:       v = -32'sd1;
                    4:       v = 32'sh00010000;   // 1.0
                    default: v = 32'shFFFF0000;   // -1.0
                endcase
            end
            default: begin
                // just inside the range ends, stresses the 33-bit sum
                if ($urandom_range(1)) begin
                    v = 32'sh7FFFFFFF - int'($urandom_range(15));
                end else begin
                    v = 32'sh80000000 + int'($urandom_range(15));
                end
            end
        endcase
        return v;
    endfunction

    task automatic send_batch(int len, sample_mix_e mix);
        if (len > MAX_SAMPLES) begin
            overflow_batches++;
        end
        for (int k = 0; k < len; k++) begin
            send_sample(pick_sample(mix), k == len - 1);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int          batch_len;
        sample_mix_e mix;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single-sample batches at both range ends
        send_sample(32'sh7FFFFFFF, 1'b1);
        send_sample(32'sh80000000, 1'b1);
        // pairs: sum overflows 32 bits both ways
        send_sample(32'sh7FFFFFFF, 1'b0);
        send_sample(32'sh7FFFFFFF, 1'b1);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh80000000, 1'b1);
        // pairs: odd sums round toward minus infinity
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh7FFFFFFF, 1'b1);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd0, 1'b1);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd2, 1'b1);
        // equal samples, odd count
        send_sample(32'sd5, 1'b0);
        send_sample(-32'sd3, 1'b0);
        send_sample(32'sd5, 1'b1);
        // descending arrival, every insert shifts the whole chain
        send_sample(32'sd3, 1'b0);
        send_sample(32'sd2, 1'b0);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd0, 1'b1);
        // +1.5 and -1.5 cancel
        send_sample(32'sh00018000, 1'b0);
        send_sample(-32'sh00018000, 1'b1);

        // random batches
        while (items_sent < ITEM_TARGET) begin
            no_idle = (items_sent >= 350 && items_sent < 650);
            mix     = sample_mix_e'($urandom_range(3));
            // a few fixed sizes around the store capacity
            if (batches_sent == 30) begin
                batch_len = MAX_SAMPLES;
            end else if (batches_sent == 45) begin
                batch_len = MAX_SAMPLES + 1;        // only the last one dropped
            end else if (batches_sent == 70) begin
                batch_len = MAX_SAMPLES + 16;
            end else if ($urandom_range(39) == 0) begin
                batch_len = $urandom_range(MAX_SAMPLES + 8, MAX_SAMPLES + 1);
            end else if ($urandom_range(9) == 0) begin
                batch_len = $urandom_range(MAX_SAMPLES, 17);
            end else begin
                batch_len = $urandom_range(16, 1);
            end
            send_batch(batch_len, mix);
            // sender holds off once until everything has drained
            if (batches_sent == 60) begin
                i_in_valid <= 1'b0;
                wait_for_drain();
            end
        end
        i_in_valid <= 1'b0;

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (tracker.pending_medians.size() != 0) begin
            $error("%0d medians never arrived", tracker.pending_medians.size());
            tracker.mismatches++;
        end

        $display("covered %0d samples in %0d batches, %0d of them longer than the store",
                 items_sent, batches_sent, overflow_batches);
        $display("checked %0d median transactions, %0d mismatches",
                 tracker.results_seen, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/bms_pkg.sv
rtl/core/bms_cell.sv
rtl/core/bms_chain.sv
rtl/core/batch_median_sorter.sv
bench/tb_batch_median_sorter.sv
